// File: hw/rtl/phw_pkg.sv
// shared types and constants of the harmonic waveshaper
package phw_pkg;

  localparam int SAMPLE_BITS = 24;

  // internal fixed point
  localparam int FRAC   = 26;
  localparam int X_W    = 29;
  localparam int X2_W   = 32;
  localparam int X3_W   = 34;
  localparam int X4_W   = 36;
  localparam int W_W    = 36;
  localparam int DRY_W  = 28;
  localparam int ACC_W  = 54;
  localparam int WET_W  = 17;
  localparam int TSH_W  = 5;
  localparam int CODE_W = 5;
  localparam int OSH    = 43 - SAMPLE_BITS;

  // constant shifts that bring a sample to the top trim exponent and to Q26
  localparam int BASE_L = (SAMPLE_BITS <= 29) ? 29 - SAMPLE_BITS : 0;
  localparam int BASE_R = (SAMPLE_BITS > 29) ? SAMPLE_BITS - 29 : 0;
  localparam int DRY_L  = (SAMPLE_BITS <= 27) ? 27 - SAMPLE_BITS : 0;
  localparam int DRY_R  = (SAMPLE_BITS > 27) ? SAMPLE_BITS - 27 : 0;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ODD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET  = 2'd3;

  localparam logic signed [5:0] TRIM_MIN  = -6'sd2;
  localparam logic signed [5:0] TRIM_MUTE = 6'sd17;
  localparam logic signed [5:0] TRIM_BIAS = 6'sd2;
  localparam logic [CODE_W-1:0] CURVE_OFF = 5'd17;
  localparam logic [WET_W-1:0]  WET_ONE   = 17'd65536;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (OSH - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ACC_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end_out;
  } out_item_t;

endpackage

// File: hw/rtl/polynomial_harmonic_waveshaper_core.sv
// harmonic waveshaper core: trim, polynomial curves, wet/dry mix, saturation
//
//   channel  ports                           handshake
//   in       start, busy, in_data            request taken when start & !busy
//   out      out_valid, out_data             one-cycle strobe, no back-pressure
//   cfg      cfg_we, cfg_idx, cfg_wdata      write when cfg_we is high
//
// one sample per clock; the result comes out of the last register stage
// the pipeline has six register stages: trim, x^2, x^3/x^4, curves, mix products, round
// busy stays low, the pipeline never holds a request
// rst_n (synchronous) clears valid bits and loads the configuration reset values
module polynomial_harmonic_waveshaper_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  phw_pkg::in_item_t                      in_data,
  output logic                                   out_valid,
  output phw_pkg::out_item_t                     out_data,
  input  logic                                   cfg_we,
  input  logic [phw_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [phw_pkg::CFG_W-1:0]              cfg_wdata
);
  import phw_pkg::*;

  localparam int LAT = 6;

  function automatic logic signed [W_W-1:0] curve_weight(input logic signed [W_W-1:0] v,
                                                         input logic [CODE_W-1:0] code);
    if (code >= CURVE_OFF) return '0;
    return v >>> code;
  endfunction

  // decoded configuration
  logic [TSH_W-1:0]  trim_sh_r, trim_sh_nxt;
  logic              mute_r, mute_nxt;
  logic [CODE_W-1:0] even_code_r, odd_code_r;
  logic [WET_W-1:0]  wet_r, wet_nxt, dwet_r, dwet_nxt;
  logic signed [5:0] cfg_trim;
  logic [WET_W-1:0]  cfg_wet;

  always_comb begin
    cfg_trim    = $signed(cfg_wdata[5:0]);
    cfg_wet     = cfg_wdata[WET_W-1:0];
    trim_sh_nxt = '0;
    mute_nxt    = 1'b0;
    if (cfg_trim >= TRIM_MUTE) begin
      mute_nxt = 1'b1;
    end else if (cfg_trim >= TRIM_MIN) begin
      trim_sh_nxt = TSH_W'(cfg_trim + TRIM_BIAS);
    end
    wet_nxt  = (cfg_wet > WET_ONE) ? WET_ONE : cfg_wet;
    dwet_nxt = WET_ONE - wet_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_sh_r   <= TSH_W'(TRIM_BIAS);
      mute_r      <= 1'b0;
      even_code_r <= CODE_W'(1);
      odd_code_r  <= CODE_W'(1);
      wet_r       <= WET_ONE;
      dwet_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TRIM: begin
          trim_sh_r <= trim_sh_nxt;
          mute_r    <= mute_nxt;
        end
        CFG_EVEN: even_code_r <= cfg_wdata[CODE_W-1:0];
        CFG_ODD:  odd_code_r  <= cfg_wdata[CODE_W-1:0];
        CFG_WET: begin
          wet_r  <= wet_nxt;
          dwet_r <= dwet_nxt;
        end
        default: ;
      endcase
    end
  end

  // valid bits and block markers
  logic [LAT-1:0] vld_r, be_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    be_r <= {be_r[LAT-2:0], in_data.block_end_in};
  end

  // stage 1: trim scaling and dry path
  logic signed [63:0]      s_wide;
  logic signed [X_W-1:0]   base;
  logic signed [X_W-1:0]   s1_x_nxt, s1_x_r;
  logic signed [DRY_W-1:0] s1_dry_nxt, s1_dry_r;

  always_comb begin
    s_wide     = 64'($signed(in_data.sample_in));
    base       = X_W'((s_wide <<< BASE_L) >>> BASE_R);
    // keep the shift signed so negative samples floor
    s1_x_nxt   = base >>> trim_sh_r;
    if (mute_r) begin
      s1_x_nxt = '0;
    end
    s1_dry_nxt = DRY_W'((s_wide <<< DRY_L) >>> DRY_R);
  end

  always_ff @(posedge clk) begin
    s1_x_r   <= s1_x_nxt;
    s1_dry_r <= s1_dry_nxt;
  end

  // stage 2: x^2
  logic signed [2*X_W-1:0] prod_xx;
  logic signed [X_W-1:0]   s2_x_r;
  logic signed [X2_W-1:0]  s2_x2_nxt, s2_x2_r;
  logic signed [DRY_W-1:0] s2_dry_r;

  always_comb begin
    prod_xx   = s1_x_r * s1_x_r;
    s2_x2_nxt = $signed(prod_xx[FRAC +: X2_W]);
  end

  always_ff @(posedge clk) begin
    s2_x_r   <= s1_x_r;
    s2_x2_r  <= s2_x2_nxt;
    s2_dry_r <= s1_dry_r;
  end

  // stage 3: x^3 and x^4
  logic signed [X2_W+X_W-1:0] prod_x3;
  logic signed [2*X2_W-1:0]   prod_x4;
  logic signed [X_W-1:0]      s3_x_r;
  logic signed [X2_W-1:0]     s3_x2_r;
  logic signed [X3_W-1:0]     s3_x3_nxt, s3_x3_r;
  logic signed [X4_W-1:0]     s3_x4_nxt, s3_x4_r;
  logic signed [DRY_W-1:0]    s3_dry_r;

  always_comb begin
    prod_x3   = s2_x2_r * s2_x_r;
    prod_x4   = s2_x2_r * s2_x2_r;
    s3_x3_nxt = $signed(prod_x3[FRAC +: X3_W]);
    s3_x4_nxt = $signed(prod_x4[FRAC +: X4_W]);
  end

  always_ff @(posedge clk) begin
    s3_x_r   <= s2_x_r;
    s3_x2_r  <= s2_x2_r;
    s3_x3_r  <= s3_x3_nxt;
    s3_x4_r  <= s3_x4_nxt;
    s3_dry_r <= s2_dry_r;
  end

  // stage 4: both curves, weighted and summed
  logic signed [W_W-1:0]   curve_p, curve_m, even_odd_sum;
  logic signed [W_W-1:0]   s4_w_nxt, s4_w_r;
  logic signed [DRY_W-1:0] s4_dry_r;

  always_comb begin
    curve_p      = (W_W'(s3_x_r) <<< 1) - W_W'(s3_x2_r);
    even_odd_sum = W_W'(s3_x2_r) + W_W'(s3_x4_r);
    curve_m      = W_W'(s3_x_r) + (W_W'(s3_x3_r) >>> 2) - (even_odd_sum >>> 4);
    s4_w_nxt     = curve_weight(curve_p, even_code_r) + curve_weight(curve_m, odd_code_r);
  end

  always_ff @(posedge clk) begin
    s4_w_r   <= s4_w_nxt;
    s4_dry_r <= s3_dry_r;
  end

  // stage 5: wet and dry products
  logic signed [ACC_W-1:0] s5_pw_nxt, s5_pw_r, s5_pd_nxt, s5_pd_r;

  always_comb begin
    s5_pw_nxt = s4_w_r * $signed({1'b0, wet_r});
    s5_pd_nxt = s4_dry_r * $signed({1'b0, dwet_r});
  end

  always_ff @(posedge clk) begin
    s5_pw_r <= s5_pw_nxt;
    s5_pd_r <= s5_pd_nxt;
  end

  // stage 6: round to output format and saturate
  logic signed [ACC_W-1:0]       mix_sum, mix_y;
  logic signed [SAMPLE_BITS-1:0] s6_y_nxt, s6_y_r;

  always_comb begin
    mix_sum = s5_pw_r + s5_pd_r;
    mix_y   = (mix_sum + RND_HALF) >>> OSH;
    if (mix_y > SAT_MAX) begin
      s6_y_nxt = SAMPLE_BITS'(SAT_MAX);
    end else if (mix_y < SAT_MIN) begin
      s6_y_nxt = SAMPLE_BITS'(SAT_MIN);
    end else begin
      s6_y_nxt = SAMPLE_BITS'(mix_y);
    end
  end

  always_ff @(posedge clk) begin
    s6_y_r <= s6_y_nxt;
  end

  assign busy                   = 1'b0;
  assign out_valid              = vld_r[LAT-1];
  assign out_data.sample_out    = s6_y_r;
  assign out_data.block_end_out = be_r[LAT-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("request did not reach the output after six cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result strobe without a request six cycles earlier");

  a_marker_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.block_end_out == $past(in_data.block_end_in, 6)))
    else $error("block marker out of step with its sample");

  a_even_powers: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (!s3_x2_r[X2_W-1] && !s3_x4_r[X4_W-1]))
    else $error("even power of x went negative");
`endif

endmodule
